@@ rtl/wide_char_escape_encoder_core_defines.svh @@
// Assertion macros for the wide character escape encoder
`ifndef WIDE_CHAR_ESCAPE_ENCODER_CORE_DEFINES_SVH
`define WIDE_CHAR_ESCAPE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define WCEE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WCEE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wcee_pkg.sv @@
// Shared types, constants and lookup functions for the escape encoder
package wcee_pkg;

    localparam int WCEE_QUEUE_DEPTH = 2;

    localparam logic [15:0] SHIFT_LOW_BOUND  = 16'h0100;
    localparam logic [15:0] SHIFT_HIGH_BOUND = 16'h0A00;
    localparam logic [15:0] SHIFT_OFFSET     = 16'hE000;
    localparam logic [7:0]  ESC_BASE         = 8'h10;
    localparam logic [7:0]  ESC_LOW_FLAG     = 8'h01;
    localparam logic [7:0]  ESC_HIGH_FLAG    = 8'h02;
    localparam logic [7:0]  LOW_ADJUST       = 8'd14;
    localparam logic [7:0]  HIGH_ADJUST      = 8'd9;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       three;
    } word_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } cp_map_t;

    function automatic cp_map_t cp1252_map(input logic [15:0] unit);
        cp_map_t m;
        m.hit = 1'b1;
        case (unit)
            16'h20AC: m.value = 8'h80;
            16'h201A: m.value = 8'h82;
            16'h0192: m.value = 8'h83;
            16'h201E: m.value = 8'h84;
            16'h2026: m.value = 8'h85;
            16'h2020: m.value = 8'h86;
            16'h2021: m.value = 8'h87;
            16'h02C6: m.value = 8'h88;
            16'h2030: m.value = 8'h89;
            16'h0160: m.value = 8'h8A;
            16'h2039: m.value = 8'h8B;
            16'h0152: m.value = 8'h8C;
            16'h017D: m.value = 8'h8E;
            16'h2018: m.value = 8'h91;
            16'h2019: m.value = 8'h92;
            16'h201C: m.value = 8'h93;
            16'h201D: m.value = 8'h94;
            16'h2022: m.value = 8'h95;
            16'h2013: m.value = 8'h96;
            16'h2014: m.value = 8'h97;
            16'h02DC: m.value = 8'h98;
            16'h2122: m.value = 8'h99;
            16'h0161: m.value = 8'h9A;
            16'h203A: m.value = 8'h9B;
            16'h0153: m.value = 8'h9C;
            16'h017E: m.value = 8'h9E;
            16'h0178: m.value = 8'h9F;
            default: begin
                m.hit   = 1'b0;
                m.value = 8'h00;
            end
        endcase
        return m;
    endfunction

    function automatic logic is_reserved(input logic [7:0] b);
        logic r;
        case (b)
            8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20, 8'h0D, 8'h0A,
            8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E, 8'h2F, 8'h5F, 8'hBD, 8'h3B,
            8'h5D, 8'h3D, 8'h23, 8'h3F, 8'h3A, 8'h3C, 8'h3E, 8'h2A, 8'h7C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/wcee_front.sv @@
// Front end: mode register, input handshake and code unit classification
module wcee_front
    import wcee_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [15:0]   s_code_unit,
    input  queue_status_t q_status,
    output logic          push,
    output word_entry_t   push_entry
);

    logic        utf8_mode_reg;
    cp_map_t     map;
    logic [15:0] unit_adj;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        hi_res;
    logic        lo_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf8_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            utf8_mode_reg <= cfg_wr_data;
        end
    end

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        map      = cp1252_map(s_code_unit);
        unit_adj = s_code_unit;
        if (s_code_unit > SHIFT_LOW_BOUND && s_code_unit < SHIFT_HIGH_BOUND) begin
            unit_adj = s_code_unit + SHIFT_OFFSET;
        end
        hi     = unit_adj[15:8];
        lo     = unit_adj[7:0];
        hi_res = is_reserved(hi);
        lo_res = is_reserved(lo);

        push_entry.byte0 = ESC_BASE | (hi_res ? ESC_HIGH_FLAG : 8'h00)
                                    | (lo_res ? ESC_LOW_FLAG : 8'h00);
        push_entry.byte1 = lo_res ? lo + LOW_ADJUST : lo;
        push_entry.byte2 = hi_res ? hi - HIGH_ADJUST : hi;
        push_entry.three = 1'b1;

        if (!utf8_mode_reg && map.hit) begin
            push_entry.byte0 = map.value;
            push_entry.three = 1'b0;
        end else if (hi == 8'h00) begin
            push_entry.byte0 = lo;
            push_entry.three = 1'b0;
        end
    end

endmodule

@@ rtl/wcee_queue.sv @@
// Small FIFO of classified words between front and back
module wcee_queue
    import wcee_pkg::*;
#(
    parameter int DEPTH = WCEE_QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  word_entry_t   push_entry,
    input  logic          pop,
    output word_entry_t   head,
    output queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    word_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

endmodule

@@ rtl/wcee_back.sv @@
// Back end: serializes each queued word into bytes on the output register
module wcee_back
    import wcee_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  word_entry_t   head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_last_byte
);

    localparam logic [1:0] SLOT_ESC  = 2'd0;
    localparam logic [1:0] SLOT_LOW  = 2'd1;
    localparam logic [1:0] SLOT_HIGH = 2'd2;

    logic [1:0] slot_reg;
    logic [1:0] slot_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_out_byte_reg;
    logic       m_last_byte_reg;
    logic       out_free;
    logic       load;
    logic [7:0] sel_byte;
    logic       sel_last;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = out_free && !q_status.empty;

    always_comb begin
        case (slot_reg)
            SLOT_ESC:  sel_byte = head.byte0;
            SLOT_LOW:  sel_byte = head.byte1;
            SLOT_HIGH: sel_byte = head.byte2;
            default:   sel_byte = head.byte2;
        endcase
        sel_last     = !head.three || (slot_reg == SLOT_HIGH);
        pop          = load && sel_last;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            slot_next = sel_last ? SLOT_ESC : slot_reg + 1'b1;
        end
        if (out_free) begin
            m_valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= SLOT_ESC;
            m_valid_reg <= 1'b0;
        end else begin
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_byte_reg  <= sel_byte;
            m_last_byte_reg <= sel_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_last_byte = m_last_byte_reg;

endmodule

@@ rtl/wide_char_escape_encoder_core.sv @@
// Top level of the wide character escape encoder
// Each accepted 16-bit code unit leaves as one byte (plain or Windows-1252 mapped) or as
// three bytes (escape, low, high), with m_last_byte marking the final byte of the unit.
// Throughput is one output byte per cycle while m_ready is high, set by the single output
// register of the back serializer. A new code unit is taken every cycle while the word
// queue (QUEUE_DEPTH entries) has room; the first output byte of a unit passes through
// the queue entry, then the output register, before it can be accepted. Write
// cfg_wr_en/cfg_wr_data (utf8_mode) only while the block is idle.
`include "wide_char_escape_encoder_core_defines.svh"

module wide_char_escape_encoder_core
    import wcee_pkg::*;
#(
    parameter int QUEUE_DEPTH = WCEE_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte
);

    queue_status_t q_status;
    word_entry_t   push_entry;
    word_entry_t   head;
    logic          push;
    logic          pop;

    wcee_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    wcee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    wcee_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

    `WCEE_ASSERT_NEXT(a_push_fills, aclk, aresetn, push, !q_status.empty, "queue empty after push")
    `WCEE_ASSERT_NEXT(a_bytes_follow, aclk, aresetn, m_valid && m_ready && !m_last_byte, m_valid, "gap inside escaped word")
    `WCEE_ASSERT_NOW(a_full_stalls, aclk, aresetn, q_status.full, !s_ready, "ready while queue full")
    `WCEE_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, pop, !q_status.empty, "pop from empty queue")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the wide character escape encoder core
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_STALL   = 200;
    localparam int CP1252_COUNT = 27;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } esc_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit = 16'h0000;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last_byte;

    logic [15:0] unit_q [$];
    esc_byte_t   escaped_q [$];
    logic        mode_shadow = 1'b0;
    logic        in_fire     = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          stall_req    = 0;
    int          stall_served = 0;
    int          stall_left   = 0;
    int          quiet_cycles = 0;
    int          errors       = 0;

    wide_char_escape_encoder_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

    always #2 aclk = ~aclk;

    function automatic logic [23:0] cp1252_entry(input int idx);
        logic [23:0] e;
        case (idx)
            0:  e = {16'h20AC, 8'h80};
            1:  e = {16'h201A, 8'h82};
            2:  e = {16'h0192, 8'h83};
            3:  e = {16'h201E, 8'h84};
            4:  e = {16'h2026, 8'h85};
            5:  e = {16'h2020, 8'h86};
            6:  e = {16'h2021, 8'h87};
            7:  e = {16'h02C6, 8'h88};
            8:  e = {16'h2030, 8'h89};
            9:  e = {16'h0160, 8'h8A};
            10: e = {16'h2039, 8'h8B};
            11: e = {16'h0152, 8'h8C};
            12: e = {16'h017D, 8'h8E};
            13: e = {16'h2018, 8'h91};
            14: e = {16'h2019, 8'h92};
            15: e = {16'h201C, 8'h93};
            16: e = {16'h201D, 8'h94};
            17: e = {16'h2022, 8'h95};
            18: e = {16'h2013, 8'h96};
            19: e = {16'h2014, 8'h97};
            20: e = {16'h02DC, 8'h98};
            21: e = {16'h2122, 8'h99};
            22: e = {16'h0161, 8'h9A};
            23: e = {16'h203A, 8'h9B};
            24: e = {16'h0153, 8'h9C};
            25: e = {16'h017E, 8'h9E};
            default: e = {16'h0178, 8'h9F};
        endcase
        return e;
    endfunction

    function automatic logic special_byte(input logic [7:0] b);
        return b inside {8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20,
                         8'h0D, 8'h0A, 8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E,
                         8'h2F, 8'h5F, 8'hBD, 8'h3B, 8'h5D, 8'h3D, 8'h23, 8'h3F,
                         8'h3A, 8'h3C, 8'h3E, 8'h2A, 8'h7C};
    endfunction

    function automatic void encode_unit(input logic [15:0] unit_in, input logic utf8);
        logic [15:0] u;
        logic [23:0] e;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  esc;
        logic        mapped;
        int          i;
        u = unit_in;
        mapped = 1'b0;
        if (!utf8) begin
            for (i = 0; i < CP1252_COUNT; i++) begin
                e = cp1252_entry(i);
                if (e[23:8] == u) begin
                    escaped_q.push_back({e[7:0], 1'b1});
                    mapped = 1'b1;
                end
            end
        end
        if (!mapped) begin
            if (u > 16'h0100 && u < 16'h0A00) begin
                u = u + 16'hE000;
            end
            hi = u[15:8];
            lo = u[7:0];
            if (hi == 8'h00) begin
                escaped_q.push_back({lo, 1'b1});
            end else begin
                esc = 8'h10;
                if (special_byte(hi)) begin
                    esc = esc + 8'd2;
                    hi  = hi - 8'd9;
                end
                if (special_byte(lo)) begin
                    esc = esc + 8'd1;
                    lo  = lo + 8'd14;
                end
                escaped_q.push_back({esc, 1'b0});
                escaped_q.push_back({lo, 1'b0});
                escaped_q.push_back({hi, 1'b1});
            end
        end
    endfunction

    function automatic logic [7:0] pick_byte(input logic want_special);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (want_special && !special_byte(b)) begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [15:0] random_unit();
        logic [23:0] e;
        logic [15:0] u;
        case ($urandom_range(7))
            0, 1: begin
                e = cp1252_entry($urandom_range(CP1252_COUNT - 1));
                u = e[23:8];
            end
            2: u = 16'($urandom_range(16'h09FF, 16'h0101));
            3: u = {8'h00, pick_byte(1'($urandom_range(1)))};
            4, 5: u = {pick_byte(1'($urandom_range(1))), pick_byte(1'($urandom_range(1)))};
            default: u = 16'($urandom_range(16'hFFFF));
        endcase
        return u;
    endfunction

    task automatic write_mode(input logic utf8);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= utf8;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = utf8;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (unit_q.size() != 0 || s_valid || escaped_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            unit_q.push_back(random_unit());
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !in_fire)) begin
            if (unit_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_code_unit <= unit_q.pop_front();
                s_valid     <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_req != stall_served) begin
            stall_served <= stall_served + 1;
            stall_left   <= LONG_STALL;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : scoreboard
        esc_byte_t want;
        in_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (escaped_q.size() == 0) begin
                    $error("unexpected word: out_byte %02h last_byte %0d",
                           m_out_byte, m_last_byte);
                    errors++;
                end else begin
                    want = escaped_q.pop_front();
                    if (m_out_byte !== want.value) begin
                        $error("out_byte: expected %02h, actual %02h", want.value, m_out_byte);
                        errors++;
                    end
                    if (m_last_byte !== want.last) begin
                        $error("last_byte: expected %0d, actual %0d", want.last, m_last_byte);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                encode_unit(s_code_unit, mode_shadow);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 6;
        rx_idle_pct = 87;
        write_mode(1'b0);
        unit_q = {16'h0000, 16'hFFFF, 16'h0100, 16'h0101, 16'h09FF, 16'h0A00,
                  16'h00FF, 16'h0080, 16'h20AC, 16'h017E, 16'h0178, 16'h4124,
                  16'h2441, 16'h5B5C, 16'hBD80, 16'h7C2A};
        wait_idle();

        write_mode(1'b1);
        unit_q = {16'h20AC, 16'h0160, 16'h0192, 16'h2122, 16'h0000, 16'hFFFF};
        wait_idle();

        // hold the result side so the block backs up its input
        queue_random(30);
        stall_req = stall_req + 1;
        wait_idle();

        tx_idle_pct = 87;
        rx_idle_pct = 6;
        write_mode(1'b0);
        queue_random(15);
        wait_idle();
        queue_random(15);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_mode(1'b1);
        queue_random(15);
        wait_idle();
        write_mode(1'b0);
        queue_random(15);
        wait_idle();

        if (errors == 0 && escaped_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
